// ===== design/cmsf_pkg.sv =====
// ----------------------------------------------------------------------------
// cmsf_pkg
// Shared types, widths and constants for the five-point cross mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cmsf_pkg;

  localparam int PIXEL_WIDTH = 16;
  localparam int MAX_COLS    = 64;
  localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int ROW_W       = 12;
  localparam int COLCNT_W    = 7;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 1'b1;

  localparam int MAX_TERMS = 5;
  localparam int CNT_W     = 3;
  localparam int SUM_W     = PIXEL_WIDTH + 3;
  localparam int MAG_W     = SUM_W - 1;
  localparam int DIV_SHIFT = MAG_W + 2;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = MAG_W + RECIP_W;
  localparam int QD_W      = MAG_W + CNT_W;

  localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((2 ** DIV_SHIFT) / 1);
  localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((2 ** DIV_SHIFT) / 2);
  localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2 ** DIV_SHIFT) / 3);
  localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((2 ** DIV_SHIFT) / 4);
  localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'((2 ** DIV_SHIFT) / 5);

  // result slots of one pixel, one-hot
  localparam logic [2:0] RES_UPPER = 3'b001;
  localparam logic [2:0] RES_LEFT  = 3'b010;
  localparam logic [2:0] RES_TAIL  = 3'b100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WR,
    ST_SUM,
    ST_MUL,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        cnt;
  } div_req_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] k;
    case (cnt)
      3'd1: k = RECIP_1;
      3'd2: k = RECIP_2;
      3'd3: k = RECIP_3;
      3'd4: k = RECIP_4;
      3'd5: k = RECIP_5;
      default: k = RECIP_1;
    endcase
    return k;
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [PIXEL_WIDTH-1:0] v);
    return SUM_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== design/cmsf_div.sv =====
// ----------------------------------------------------------------------------
// cmsf_div
// Signed divide of a neighborhood sum by a count of 1 to 5, truncating
// toward zero: reciprocal multiply, registered, then one-step correction.
// ----------------------------------------------------------------------------
`default_nettype none

module cmsf_div (
  input  wire logic                                    clk,
  input  wire logic                                    load,
  input  wire cmsf_pkg::div_req_t                      req,
  output logic signed [cmsf_pkg::PIXEL_WIDTH-1:0]      quotient
);

  logic                               neg;
  logic signed [cmsf_pkg::SUM_W-1:0]  abs_sum;
  logic [cmsf_pkg::MAG_W-1:0]         mag;
  logic [cmsf_pkg::PROD_W-1:0]        prod;

  logic [cmsf_pkg::MAG_W-1:0]         q0;
  logic [cmsf_pkg::MAG_W-1:0]         mag_r;
  logic [cmsf_pkg::CNT_W-1:0]         cnt_r;
  logic                               neg_r;

  logic [cmsf_pkg::QD_W-1:0]          qd;
  logic [cmsf_pkg::QD_W-1:0]          rem;
  logic [cmsf_pkg::MAG_W-1:0]         q;
  logic [cmsf_pkg::MAG_W-1:0]         signed_q;

  always_comb begin
    neg     = req.sum[cmsf_pkg::SUM_W-1];
    abs_sum = neg ? -req.sum : req.sum;
    mag     = abs_sum[cmsf_pkg::MAG_W-1:0];
    prod    = cmsf_pkg::PROD_W'(mag) * cmsf_pkg::PROD_W'(cmsf_pkg::recip(req.cnt));
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q0    <= prod[cmsf_pkg::DIV_SHIFT+cmsf_pkg::MAG_W-1:cmsf_pkg::DIV_SHIFT];
      mag_r <= mag;
      cnt_r <= req.cnt;
      neg_r <= neg;
    end
  end

  // estimate is low by at most one
  always_comb begin
    qd       = cmsf_pkg::QD_W'(q0) * cmsf_pkg::QD_W'(cnt_r);
    rem      = cmsf_pkg::QD_W'(mag_r) - qd;
    q        = (rem >= cmsf_pkg::QD_W'(cnt_r)) ? q0 + cmsf_pkg::MAG_W'(1) : q0;
    signed_q = neg_r ? -q : q;
    quotient = signed_q[cmsf_pkg::PIXEL_WIDTH-1:0];
  end

endmodule

`default_nettype wire

// ===== design/cross_mean_smoothing_filter_top.sv =====
// ----------------------------------------------------------------------------
// cross_mean_smoothing_filter_top
// Sequence: a taken pixel word passes RD0, RD1, RD2 and the store write WR,
//   then each of its results passes SUM, MUL and DIV, DIV waiting while the
//   output word is held. No new pixel is taken before the last is done, a pace
//   set by the single read port of each line store and the shared divider.
// Reset: counts go to 1, row/column position and store select to 0; the line
//   stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_mean_smoothing_filter_top (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_write,
  input  wire logic [cmsf_pkg::CFG_INDEX_W-1:0]          cfg_index,
  input  wire logic [cmsf_pkg::CFG_DATA_W-1:0]           cfg_data,
  input  wire logic                                      pixel_valid,
  output logic                                           pixel_stall,
  input  wire logic signed [cmsf_pkg::PIXEL_WIDTH-1:0]   pixel_in,
  output logic                                           mean_valid,
  input  wire logic                                      mean_stall,
  output logic signed [cmsf_pkg::PIXEL_WIDTH-1:0]        mean_value,
  output logic                                           run_last,
  output logic                                           frame_last
);

  localparam int PW  = cmsf_pkg::PIXEL_WIDTH;
  localparam int CW  = cmsf_pkg::COL_W;
  localparam int NW  = cmsf_pkg::CNT_W;

  cmsf_pkg::state_t state, state_next;

  logic [cmsf_pkg::ROW_W-1:0]    row_count;
  logic [cmsf_pkg::COLCNT_W-1:0] col_count;
  logic [cmsf_pkg::ROW_W-1:0]    row_index;
  logic [CW-1:0]                 col_index;
  logic                          store_select;

  logic [cmsf_pkg::ROW_W-1:0]    rows_eff;
  logic [cmsf_pkg::COLCNT_W-1:0] cols_eff;
  logic                          is_final;
  logic                          is_end;
  logic                          accept;

  // per-pixel context
  logic [CW-1:0]         item_col;
  logic                  item_sel;
  logic signed [PW-1:0]  item_pixel;
  logic                  item_final;
  logic                  item_end;
  logic                  c_ge1, c_ge2, r_ge1, r_ge2;

  // line stores
  logic signed [PW-1:0]  mem_a [cmsf_pkg::MAX_COLS];
  logic signed [PW-1:0]  mem_b [cmsf_pkg::MAX_COLS];
  logic signed [PW-1:0]  rd_a, rd_b;
  logic [CW-1:0]         prev_addr, older_addr, addr_a, addr_b;
  logic signed [PW-1:0]  prev_rd, older_rd;
  logic                  mem_we, we_a, we_b;

  logic signed [PW-1:0]  p_m1, p_0, p_p1, o_m2, o_m1, o_0;

  logic [2:0]            pend, pend_init, cur, rest;
  logic                  sum_load, div_load, out_load;

  cmsf_pkg::div_req_t    req_comb, div_req;
  logic                  res_last, res_frame;
  logic signed [PW-1:0]  quotient;

  assign accept      = pixel_valid && !pixel_stall;
  assign pixel_stall = (state != cmsf_pkg::ST_IDLE);

  always_comb begin
    rows_eff = (row_count == '0) ? cmsf_pkg::ROW_W'(1) : row_count;
    if (col_count == '0) begin
      cols_eff = cmsf_pkg::COLCNT_W'(1);
    end else if (col_count > cmsf_pkg::COLCNT_W'(cmsf_pkg::MAX_COLS)) begin
      cols_eff = cmsf_pkg::COLCNT_W'(cmsf_pkg::MAX_COLS);
    end else begin
      cols_eff = col_count;
    end
    is_final = ({1'b0, row_index} + (cmsf_pkg::ROW_W+1)'(1)) >= {1'b0, rows_eff};
    is_end   = (cmsf_pkg::COLCNT_W'(col_index) + cmsf_pkg::COLCNT_W'(1)) >= cols_eff;
  end

  // configuration and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= cmsf_pkg::ROW_W'(1);
      col_count    <= cmsf_pkg::COLCNT_W'(1);
      row_index    <= '0;
      col_index    <= '0;
      store_select <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          cmsf_pkg::REG_ROW_COUNT: row_count <= cfg_data[cmsf_pkg::ROW_W-1:0];
          cmsf_pkg::REG_COL_COUNT: col_count <= cfg_data[cmsf_pkg::COLCNT_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (is_end) begin
          col_index    <= '0;
          row_index    <= is_final ? '0 : row_index + cmsf_pkg::ROW_W'(1);
          store_select <= !store_select;
        end else begin
          col_index <= col_index + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_col   <= col_index;
      item_sel   <= store_select;
      item_pixel <= pixel_in;
      item_final <= is_final;
      item_end   <= is_end;
      c_ge1      <= (col_index >= CW'(1));
      c_ge2      <= (col_index >= CW'(2)) && (cmsf_pkg::MAX_COLS > 2);
      r_ge1      <= (row_index >= cmsf_pkg::ROW_W'(1));
      r_ge2      <= (row_index >= cmsf_pkg::ROW_W'(2));
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cmsf_pkg::ST_IDLE: if (accept) state_next = cmsf_pkg::ST_RD0;
      cmsf_pkg::ST_RD0:  state_next = cmsf_pkg::ST_RD1;
      cmsf_pkg::ST_RD1:  state_next = cmsf_pkg::ST_RD2;
      cmsf_pkg::ST_RD2:  state_next = cmsf_pkg::ST_WR;
      cmsf_pkg::ST_WR: begin
        state_next = (pend_init == 3'b000) ? cmsf_pkg::ST_IDLE : cmsf_pkg::ST_SUM;
      end
      cmsf_pkg::ST_SUM:  state_next = cmsf_pkg::ST_MUL;
      cmsf_pkg::ST_MUL:  state_next = cmsf_pkg::ST_DIV;
      cmsf_pkg::ST_DIV: begin
        if (out_load) begin
          state_next = (rest == 3'b000) ? cmsf_pkg::ST_IDLE : cmsf_pkg::ST_SUM;
        end
      end
      default: state_next = cmsf_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    prev_addr  = item_col;
    older_addr = item_col;
    mem_we     = 1'b0;
    sum_load   = 1'b0;
    div_load   = 1'b0;
    out_load   = 1'b0;
    case (state)
      cmsf_pkg::ST_RD0: begin
        prev_addr  = item_col - CW'(1);
        older_addr = item_col - CW'(2);
      end
      cmsf_pkg::ST_RD1: begin
        prev_addr  = item_col;
        older_addr = item_col - CW'(1);
      end
      cmsf_pkg::ST_RD2: begin
        prev_addr  = item_col + CW'(1);
        older_addr = item_col;
      end
      cmsf_pkg::ST_WR:  mem_we   = 1'b1;
      cmsf_pkg::ST_SUM: sum_load = 1'b1;
      cmsf_pkg::ST_MUL: div_load = 1'b1;
      cmsf_pkg::ST_DIV: out_load = !mean_valid || !mean_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store select picks the previous row; the other store is overwritten
  assign addr_a   = item_sel ? older_addr : prev_addr;
  assign addr_b   = item_sel ? prev_addr : older_addr;
  assign prev_rd  = item_sel ? rd_b : rd_a;
  assign older_rd = item_sel ? rd_a : rd_b;
  assign we_a     = mem_we && item_sel;
  assign we_b     = mem_we && !item_sel;

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[item_col] <= item_pixel;
    end
    rd_a <= mem_a[addr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[item_col] <= item_pixel;
    end
    rd_b <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    case (state)
      cmsf_pkg::ST_RD1: begin
        p_m1 <= prev_rd;
        o_m2 <= older_rd;
      end
      cmsf_pkg::ST_RD2: begin
        p_0  <= prev_rd;
        o_m1 <= older_rd;
      end
      cmsf_pkg::ST_WR: begin
        p_p1 <= prev_rd;
        o_0  <= older_rd;
      end
      default: ;
    endcase
  end

  // pending results of the current pixel
  always_comb begin
    pend_init = {item_final && item_end, item_final && c_ge1, r_ge1};
    cur       = pend & (~pend + 3'b001);
    rest      = pend & ~cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 3'b000;
    end else if (state == cmsf_pkg::ST_WR) begin
      pend <= pend_init;
    end else if (out_load) begin
      pend <= rest;
    end
  end

  always_comb begin
    case (cur)
      cmsf_pkg::RES_UPPER: begin
        req_comb.sum = cmsf_pkg::sx(p_0) + cmsf_pkg::sx(item_pixel)
                     + (c_ge1 ? cmsf_pkg::sx(p_m1) : '0)
                     + (!item_end ? cmsf_pkg::sx(p_p1) : '0)
                     + (r_ge2 ? cmsf_pkg::sx(o_0) : '0);
        req_comb.cnt = NW'(2) + NW'(c_ge1) + NW'(!item_end) + NW'(r_ge2);
      end
      cmsf_pkg::RES_LEFT: begin
        req_comb.sum = cmsf_pkg::sx(o_m1) + cmsf_pkg::sx(item_pixel)
                     + (c_ge2 ? cmsf_pkg::sx(o_m2) : '0)
                     + (r_ge1 ? cmsf_pkg::sx(p_m1) : '0);
        req_comb.cnt = NW'(2) + NW'(c_ge2) + NW'(r_ge1);
      end
      default: begin
        req_comb.sum = cmsf_pkg::sx(item_pixel)
                     + (c_ge1 ? cmsf_pkg::sx(o_m1) : '0)
                     + (r_ge1 ? cmsf_pkg::sx(p_0) : '0);
        req_comb.cnt = NW'(1) + NW'(c_ge1) + NW'(r_ge1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sum_load) begin
      div_req   <= req_comb;
      res_last  <= (rest == 3'b000);
      res_frame <= (cur == cmsf_pkg::RES_TAIL);
    end
  end

  cmsf_div u_div (
    .clk      (clk),
    .load     (div_load),
    .req      (div_req),
    .quotient (quotient)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (out_load) begin
      mean_valid <= 1'b1;
    end else if (!mean_stall) begin
      mean_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mean_value <= quotient;
      run_last   <= res_last;
      frame_last <= res_frame;
    end
  end

  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    mean_valid && frame_last |-> run_last)
    else $error("frame end word without run end");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == cmsf_pkg::ST_MUL |->
      (div_req.cnt != '0) && (div_req.cnt <= NW'(cmsf_pkg::MAX_TERMS)))
    else $error("divisor out of range");

  a_div_pend: assert property (@(posedge clk) disable iff (rst)
    (state == cmsf_pkg::ST_SUM || state == cmsf_pkg::ST_DIV) |-> pend != 3'b000)
    else $error("result stage with nothing pending");

endmodule

`default_nettype wire

// ===== verif/cmsf_mean_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cmsf_mean_checker
// Watches the config port and both streams of the cross mean filter. Keeps its
// own copy of the line stores, position and counts, works out the means that
// each taken pixel releases and compares every mean word against the oldest
// one still owed.
// ----------------------------------------------------------------------------

module cmsf_mean_checker (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write,
  input  wire logic [cmsf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [cmsf_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  wire logic                                    pixel_valid,
  input  wire logic                                    pixel_stall,
  input  wire logic signed [cmsf_pkg::PIXEL_WIDTH-1:0] pixel_in,
  input  wire logic                                    mean_valid,
  input  wire logic                                    mean_stall,
  input  wire logic signed [cmsf_pkg::PIXEL_WIDTH-1:0] mean_value,
  input  wire logic                                    run_last,
  input  wire logic                                    frame_last,
  output int                                           errors,
  output int                                           pending
);

  typedef struct packed {
    logic signed [cmsf_pkg::PIXEL_WIDTH-1:0] mean;
    logic                                    run_end;
    logic                                    frame_end;
  } mean_word_t;

  mean_word_t                              expected_means[$];
  logic signed [cmsf_pkg::PIXEL_WIDTH-1:0] line_a [cmsf_pkg::MAX_COLS];
  logic signed [cmsf_pkg::PIXEL_WIDTH-1:0] line_b [cmsf_pkg::MAX_COLS];
  logic [cmsf_pkg::ROW_W-1:0]              rows_cfg;
  logic [cmsf_pkg::COLCNT_W-1:0]           cols_cfg;
  logic [cmsf_pkg::ROW_W-1:0]              row_pos;
  logic [cmsf_pkg::COL_W-1:0]              col_pos;
  logic                                    prev_in_b;
  int                                      mismatch_count = 0;

  function automatic int line_word(input logic from_b, input int idx);
    return from_b ? int'(line_b[idx]) : int'(line_a[idx]);
  endfunction

  function automatic void push_mean(input int sum, input int cnt, input logic frame_end);
    mean_word_t w;
    w.mean      = cmsf_pkg::PIXEL_WIDTH'(sum / cnt);
    w.run_end   = 1'b0;
    w.frame_end = frame_end;
    expected_means.push_back(w);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic predict_means(input logic signed [cmsf_pkg::PIXEL_WIDTH-1:0] pix);
    int   rows, cols, c, r, x, sum, cnt, n;
    logic older_b, final_row, end_col;
    rows      = (rows_cfg == 0) ? 1 : int'(rows_cfg);
    cols      = (cols_cfg == 0) ? 1 :
                ((cols_cfg > cmsf_pkg::MAX_COLS) ? cmsf_pkg::MAX_COLS : int'(cols_cfg));
    c         = int'(col_pos);
    r         = int'(row_pos);
    x         = int'(pix);
    older_b   = !prev_in_b;
    final_row = (r + 1 >= rows);
    end_col   = (c + 1 >= cols);
    n         = 0;

    // pixel above is now complete
    if (r >= 1) begin
      sum = line_word(prev_in_b, c) + x;
      cnt = 2;
      if (c >= 1) begin
        sum += line_word(prev_in_b, c - 1);
        cnt++;
      end
      if (c + 1 < cols) begin
        sum += line_word(prev_in_b, c + 1);
        cnt++;
      end
      if (r >= 2) begin
        sum += line_word(older_b, c);
        cnt++;
      end
      push_mean(sum, cnt, 1'b0);
      n++;
    end

    if (older_b) line_b[c] = pix;
    else line_a[c] = pix;

    // last row trails one column behind
    if (final_row) begin
      if (c >= 1) begin
        sum = line_word(older_b, c - 1) + x;
        cnt = 2;
        if (c >= 2) begin
          sum += line_word(older_b, c - 2);
          cnt++;
        end
        if (r >= 1) begin
          sum += line_word(prev_in_b, c - 1);
          cnt++;
        end
        push_mean(sum, cnt, 1'b0);
        n++;
      end
      if (end_col) begin
        sum = x;
        cnt = 1;
        if (c >= 1) begin
          sum += line_word(older_b, c - 1);
          cnt++;
        end
        if (r >= 1) begin
          sum += line_word(prev_in_b, c);
          cnt++;
        end
        push_mean(sum, cnt, 1'b1);
        n++;
      end
    end

    if (n > 0) expected_means[expected_means.size() - 1].run_end = 1'b1;

    if (end_col) begin
      col_pos   = '0;
      row_pos   = final_row ? '0 : cmsf_pkg::ROW_W'(r + 1);
      prev_in_b = !prev_in_b;
    end else begin
      col_pos = cmsf_pkg::COL_W'(c + 1);
    end
  endtask

  task automatic check_mean_word();
    mean_word_t want;
    if (expected_means.size() == 0) begin
      report_mismatch("unexpected mean word", int'(mean_value), 0);
      return;
    end
    want = expected_means.pop_front();
    if (mean_value !== want.mean)
      report_mismatch("mean_value", int'(mean_value), int'(want.mean));
    if (run_last !== want.run_end)
      report_mismatch("run_last", int'(run_last), int'(want.run_end));
    if (frame_last !== want.frame_end)
      report_mismatch("frame_last", int'(frame_last), int'(want.frame_end));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_cfg  = cmsf_pkg::ROW_W'(1);
      cols_cfg  = cmsf_pkg::COLCNT_W'(1);
      row_pos   = '0;
      col_pos   = '0;
      prev_in_b = 1'b0;
      foreach (line_a[i]) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      expected_means.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == cmsf_pkg::REG_ROW_COUNT) begin
          rows_cfg = cfg_data[cmsf_pkg::ROW_W-1:0];
        end else if (cfg_index == cmsf_pkg::REG_COL_COUNT) begin
          cols_cfg = cfg_data[cmsf_pkg::COLCNT_W-1:0];
        end
      end
      if (pixel_valid && !pixel_stall) predict_means(pixel_in);
      if (mean_valid && !mean_stall) check_mean_word();
    end
    pending <= expected_means.size();
    errors  <= mismatch_count;
  end

endmodule

// ===== verif/tb_cross_mean_smoothing_filter_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cross_mean_smoothing_filter_top
// Drives frames of signed pixels into the cross mean filter: corner frames,
// zero and oversized counts, a very tall frame, counts changed inside a frame,
// a long output hold-off, then random frames under several idle patterns.
// A side checker predicts and compares; a watchdog catches hangs.
// ----------------------------------------------------------------------------

module tb_cross_mean_smoothing_filter_top;

  localparam int PW = cmsf_pkg::PIXEL_WIDTH;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic signed [PW-1:0] PIX_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PIX_MIN = {1'b1, {(PW-1){1'b0}}};

  logic                                 clk         = 1'b0;
  logic                                 rst         = 1'b1;
  logic                                 cfg_write   = 1'b0;
  logic [cmsf_pkg::CFG_INDEX_W-1:0]     cfg_index   = cmsf_pkg::REG_ROW_COUNT;
  logic [cmsf_pkg::CFG_DATA_W-1:0]      cfg_data    = '0;
  logic                                 pixel_valid = 1'b0;
  logic signed [PW-1:0]                 pixel_in    = '0;
  logic                                 mean_stall  = 1'b0;
  logic                                 pixel_stall;
  logic                                 mean_valid;
  logic signed [PW-1:0]                 mean_value;
  logic                                 run_last;
  logic                                 frame_last;

  int errors;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;

  logic signed [PW-1:0] corner_px [9] = '{
    PIX_MIN, PIX_MIN, PIX_MAX, -16'sd7, 16'sd5, PIX_MIN, PIX_MAX, PIX_MAX, -16'sd1
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cross_mean_smoothing_filter_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_in    (pixel_in),
    .mean_valid  (mean_valid),
    .mean_stall  (mean_stall),
    .mean_value  (mean_value),
    .run_last    (run_last),
    .frame_last  (frame_last)
  );

  cmsf_mean_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_in    (pixel_in),
    .mean_valid  (mean_valid),
    .mean_stall  (mean_stall),
    .mean_value  (mean_value),
    .run_last    (run_last),
    .frame_last  (frame_last),
    .errors      (errors),
    .pending     (pending)
  );

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      mean_stall <= 1'b1;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      mean_stall  <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      mean_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (mean_valid && !mean_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("cross_mean_smoothing_filter_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 80;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 80;
      end
      default: begin
        send_idle_pct  = 15;
        recv_stall_pct = 15;
      end
    endcase
  endtask

  task automatic write_reg(input logic [cmsf_pkg::CFG_INDEX_W-1:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cmsf_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic signed [PW-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_in    <= pix;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  function automatic logic signed [PW-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return PIX_MIN;
      1: return PIX_MAX;
      2: return PW'($urandom_range(14)) - 16'sd7;
      default: return PW'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int nrows, input int ncols);
    repeat (nrows * ncols) send_pixel(rand_pixel());
  endtask

  // wait for every owed mean word, then let the block go quiet
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int nrows, ncols, sent;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // counts after reset give one-pixel frames
    set_idle(IDLE_NONE);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel('0);
    drain();

    write_reg(cmsf_pkg::REG_ROW_COUNT, 3);
    write_reg(cmsf_pkg::REG_COL_COUNT, 3);
    foreach (corner_px[i]) send_pixel(corner_px[i]);
    drain();

    // zero counts act as one
    write_reg(cmsf_pkg::REG_ROW_COUNT, 0);
    write_reg(cmsf_pkg::REG_COL_COUNT, 0);
    send_pixel(-16'sd3);
    send_pixel(PIX_MAX);
    drain();

    write_reg(cmsf_pkg::REG_ROW_COUNT, 2);
    write_reg(cmsf_pkg::REG_COL_COUNT, 2);
    send_frame(2, 2);
    drain();

    // column count past the store depth clamps
    set_idle(IDLE_SENDER);
    write_reg(cmsf_pkg::REG_ROW_COUNT, 1);
    write_reg(cmsf_pkg::REG_COL_COUNT, 100);
    send_frame(1, cmsf_pkg::MAX_COLS);
    drain();

    // tallest frame, cut short by a row count change
    set_idle(IDLE_RECEIVER);
    write_reg(cmsf_pkg::REG_ROW_COUNT, 4095);
    write_reg(cmsf_pkg::REG_COL_COUNT, 1);
    send_frame(20, 1);
    drain();
    write_reg(cmsf_pkg::REG_ROW_COUNT, 0);
    send_pixel(rand_pixel());
    drain();

    // both counts shrink in the middle of a row
    set_idle(IDLE_BOTH);
    write_reg(cmsf_pkg::REG_ROW_COUNT, 5);
    write_reg(cmsf_pkg::REG_COL_COUNT, 6);
    send_frame(1, 14);
    drain();
    write_reg(cmsf_pkg::REG_ROW_COUNT, 2);
    write_reg(cmsf_pkg::REG_COL_COUNT, 4);
    send_frame(1, 2);
    drain();

    // long output hold-off while pixels keep coming
    set_idle(IDLE_NONE);
    write_reg(cmsf_pkg::REG_ROW_COUNT, 3);
    write_reg(cmsf_pkg::REG_COL_COUNT, 16);
    hold_requests = hold_requests + 1;
    send_frame(3, 16);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_idle(idle_mode_t'(p % 4));
      nrows = $urandom_range(1, 5);
      ncols = $urandom_range(1, 8);
      write_reg(cmsf_pkg::REG_ROW_COUNT, nrows);
      write_reg(cmsf_pkg::REG_COL_COUNT, ($urandom_range(31) << cmsf_pkg::COLCNT_W) | ncols);
      sent = 0;
      while (sent < 20) begin
        send_frame(nrows, ncols);
        sent += nrows * ncols;
      end
      drain();
    end

    if (errors == 0) begin
      $display("cross_mean_smoothing_filter_top regression: pass");
    end else begin
      $display("cross_mean_smoothing_filter_top regression: fail");
    end
    $finish;
  end

endmodule
